>>> hdl/dtnb_pkg.sv
// dtnb_pkg: shared types and constants of the depth timestamp nearest buffer.
// Used by dtnb_ctrl, dtnb_datapath and depth_timestamp_nearest_buffer_unit.
// No dependencies.
package dtnb_pkg;

  localparam int TIME_W        = 48;
  localparam int HANDLE_W      = 16;
  localparam int JUMP_W        = 32;
  localparam int FILL_OUT_W    = 5;
  localparam int CFG_IDX_W     = 1;
  localparam int DEPTH_DEFAULT = 16;

  localparam logic [JUMP_W-1:0] JUMP_RESET   = 32'd1000000;
  localparam logic              ENABLE_RESET = 1'b1;

  // item commands
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_JUMP   = 1'b1;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_REPLACED = 3'd1,
    ST_REJECTED = 3'd2,
    ST_MATCH    = 3'd3,
    ST_NOMATCH  = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE   = 1'b0,
    S_COMMIT = 1'b1
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic commit;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

>>> hdl/dtnb_ctrl.sv
// dtnb_ctrl: two-state sequencer, capture then commit.
// Depends on dtnb_pkg for state_t, ctrl_cmd_t and dp_status_t.
module dtnb_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  dtnb_pkg::dp_status_t  status,
  output dtnb_pkg::ctrl_cmd_t   cmd
);

  dtnb_pkg::state_t state_r;
  dtnb_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dtnb_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dtnb_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = dtnb_pkg::S_COMMIT;
        end
      end
      dtnb_pkg::S_COMMIT: begin
        // wait here until the output register can take the beat
        if (status.out_free) begin
          state_nxt = dtnb_pkg::S_IDLE;
        end
      end
      default: state_nxt = dtnb_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = 1'b1;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state_r)
      dtnb_pkg::S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      dtnb_pkg::S_COMMIT: begin
        cmd.commit = status.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

>>> hdl/dtnb_datapath.sv
// dtnb_datapath: sorted row of timestamp cells, config registers and output register.
// Depends on dtnb_pkg; driven by dtnb_ctrl through ctrl_cmd_t.
module dtnb_datapath #(
  parameter int DEPTH = dtnb_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [dtnb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dtnb_pkg::JUMP_W-1:0]         cfg_wdata,
  input  logic                                in_cmd,
  input  logic [dtnb_pkg::TIME_W-1:0]         in_sample_time,
  input  logic [dtnb_pkg::HANDLE_W-1:0]       in_frame_handle,
  input  logic                                in_payload_valid,
  input  dtnb_pkg::ctrl_cmd_t                 ctrl,
  output dtnb_pkg::dp_status_t                status,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic [2:0]                          out_status,
  output logic [dtnb_pkg::TIME_W-1:0]         out_match_time,
  output logic [dtnb_pkg::HANDLE_W-1:0]       out_match_handle,
  output logic                                out_store_flushed,
  output logic [dtnb_pkg::FILL_OUT_W-1:0]     out_fill_count
);

  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam int TW     = dtnb_pkg::TIME_W;
  localparam int HW     = dtnb_pkg::HANDLE_W;

  // store: oldest entry in cell 0, entries below fill_r are valid
  logic [TW-1:0]     stamp_r  [DEPTH];
  logic [HW-1:0]     handle_r [DEPTH];
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;
  logic [TW-1:0]     newest_r;
  logic [TW-1:0]     newest_nxt;

  logic                       en_r;
  logic [dtnb_pkg::JUMP_W-1:0] jump_r;

  // captured item and compare flags
  logic              cmd_r;
  logic [TW-1:0]     time_r;
  logic [HW-1:0]     hin_r;
  logic              pv_r;
  logic [DEPTH-1:0]  lt_r;
  logic [DEPTH-1:0]  eq_r;
  logic              flush_r;
  logic              gt_newest_r;

  logic [DEPTH-1:0]  valid_now;
  logic [DEPTH-1:0]  lt_c;
  logic [DEPTH-1:0]  eq_c;
  logic              flush_c;
  logic              gt_c;

  // output register
  logic                          out_valid_r;
  dtnb_pkg::status_t             out_status_r;
  logic [TW-1:0]                 out_time_r;
  logic [HW-1:0]                 out_handle_r;
  logic                          out_flushed_r;
  logic [dtnb_pkg::FILL_OUT_W-1:0] out_fill_r;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r   <= dtnb_pkg::ENABLE_RESET;
      jump_r <= dtnb_pkg::JUMP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dtnb_pkg::CFG_ENABLE: en_r   <= cfg_wdata[0];
        dtnb_pkg::CFG_JUMP:   jump_r <= cfg_wdata;
        default:              en_r   <= en_r;
      endcase
    end
  end

  // ---------------- capture cycle: compare every cell against the new time ----------------
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      valid_now[i] = FILL_W'(i) < fill_r;
      lt_c[i]      = valid_now[i] && (stamp_r[i] < in_sample_time);
      eq_c[i]      = valid_now[i] && (stamp_r[i] == in_sample_time);
    end
    flush_c = (fill_r != '0) &&
              (({1'b0, in_sample_time} + {{(TW - dtnb_pkg::JUMP_W + 1){1'b0}}, jump_r})
               < {1'b0, newest_r});
    gt_c    = in_sample_time > newest_r;
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cmd_r       <= in_cmd;
      time_r      <= in_sample_time;
      hin_r       <= in_frame_handle;
      pv_r        <= in_payload_valid;
      lt_r        <= lt_c;
      eq_r        <= eq_c;
      flush_r     <= flush_c;
      gt_newest_r <= gt_c;
    end
  end

  // ---------------- commit cycle ----------------
  logic              is_query;
  logic              reject;
  logic              add_ok;
  logic [DEPTH-1:0]  lt_e;
  logic [DEPTH-1:0]  eq_e;
  logic [DEPTH-1:0]  valid_e;
  logic [FILL_W-1:0] fill_e;
  logic              full;
  logic              dup;

  assign is_query = (cmd_r == dtnb_pkg::CMD_QUERY);
  assign reject   = !is_query && (!en_r || !pv_r || (time_r == '0));
  assign add_ok   = !is_query && !reject;

  // a backward jump empties the store before the add proceeds
  assign lt_e   = flush_r ? '0 : lt_r;
  assign eq_e   = flush_r ? '0 : eq_r;
  assign fill_e = flush_r ? '0 : fill_r;
  assign full   = (fill_e == FILL_W'(DEPTH));
  assign dup    = |eq_e;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      valid_e[i] = FILL_W'(i) < fill_e;
    end
  end

  genvar g;
  for (g = 0; g < DEPTH; g++) begin : g_cell
    logic          lt_dn;
    logic          valid_dn;
    logic          lt_up;
    logic [TW-1:0] dn_stamp;
    logic [TW-1:0] up_stamp;
    logic [HW-1:0] dn_handle;
    logic [HW-1:0] up_handle;
    logic [TW-1:0] cell_stamp_nxt;
    logic [HW-1:0] cell_handle_nxt;

    if (g == 0) begin : g_first
      // the first cell takes the new entry whenever nothing is older
      assign lt_dn     = 1'b1;
      assign valid_dn  = 1'b0;
      assign dn_stamp  = '0;
      assign dn_handle = '0;
    end else begin : g_lower
      assign lt_dn     = lt_e[g-1];
      assign valid_dn  = valid_e[g-1];
      assign dn_stamp  = stamp_r[g-1];
      assign dn_handle = handle_r[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign lt_up     = 1'b0;
      assign up_stamp  = '0;
      assign up_handle = '0;
    end else begin : g_upper
      assign lt_up     = lt_e[g+1];
      assign up_stamp  = stamp_r[g+1];
      assign up_handle = handle_r[g+1];
    end

    always_comb begin
      cell_stamp_nxt  = stamp_r[g];
      cell_handle_nxt = handle_r[g];
      if (add_ok) begin
        if (dup) begin
          if (eq_e[g]) begin
            cell_handle_nxt = hin_r;
          end
        end else if (full) begin
          // drop the oldest: older cells advance toward cell 0
          if (lt_e[g]) begin
            if (lt_up) begin
              cell_stamp_nxt  = up_stamp;
              cell_handle_nxt = up_handle;
            end else begin
              cell_stamp_nxt  = time_r;
              cell_handle_nxt = hin_r;
            end
          end
        end else if (!lt_e[g]) begin
          if (lt_dn) begin
            cell_stamp_nxt  = time_r;
            cell_handle_nxt = hin_r;
          end else if (valid_dn) begin
            cell_stamp_nxt  = dn_stamp;
            cell_handle_nxt = dn_handle;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (ctrl.commit) begin
        stamp_r[g]  <= cell_stamp_nxt;
        handle_r[g] <= cell_handle_nxt;
      end
    end
  end

  always_comb begin
    fill_nxt   = fill_r;
    newest_nxt = newest_r;
    if (add_ok) begin
      fill_nxt = (dup || full) ? fill_e : fill_e + FILL_W'(1);
      if (!dup && ((fill_e == '0) || gt_newest_r)) begin
        newest_nxt = time_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      newest_r <= '0;
    end else if (ctrl.commit) begin
      fill_r   <= fill_nxt;
      newest_r <= newest_nxt;
    end
  end

  // nearest match: the store is sorted, so only the neighbors around the
  // insertion point compete; the earlier one wins a tie
  logic [DEPTH-1:0] lo_sel;
  logic [DEPTH-1:0] hi_sel;
  logic [TW-1:0]    lo_t;
  logic [TW-1:0]    hi_t;
  logic [HW-1:0]    lo_h;
  logic [HW-1:0]    hi_h;
  logic [TW-1:0]    d_lo;
  logic [TW-1:0]    d_hi;
  logic             lo_any;
  logic             hi_any;
  logic             pick_lo;
  logic             q_ok;

  assign lo_sel = lt_r & ~(lt_r >> 1);
  assign hi_sel = ~lt_r & {lt_r[DEPTH-2:0], 1'b1} &
                  ~({DEPTH{1'b1}} << fill_r);

  always_comb begin
    lo_t = '0;
    hi_t = '0;
    lo_h = '0;
    hi_h = '0;
    for (int i = 0; i < DEPTH; i++) begin
      lo_t = lo_t | ({TW{lo_sel[i]}} & stamp_r[i]);
      hi_t = hi_t | ({TW{hi_sel[i]}} & stamp_r[i]);
      lo_h = lo_h | ({HW{lo_sel[i]}} & handle_r[i]);
      hi_h = hi_h | ({HW{hi_sel[i]}} & handle_r[i]);
    end
  end

  assign lo_any  = |lo_sel;
  assign hi_any  = |hi_sel;
  assign d_lo    = time_r - lo_t;
  assign d_hi    = hi_t - time_r;
  assign pick_lo = lo_any && (!hi_any || (d_lo <= d_hi));
  assign q_ok    = en_r && (fill_r != '0);

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      out_time_r    <= '0;
      out_handle_r  <= '0;
      out_flushed_r <= 1'b0;
      out_fill_r    <= dtnb_pkg::FILL_OUT_W'(fill_nxt);
      if (is_query) begin
        if (q_ok) begin
          out_status_r <= dtnb_pkg::ST_MATCH;
          out_time_r   <= pick_lo ? lo_t : hi_t;
          out_handle_r <= pick_lo ? lo_h : hi_h;
        end else begin
          out_status_r <= dtnb_pkg::ST_NOMATCH;
        end
      end else if (reject) begin
        out_status_r <= dtnb_pkg::ST_REJECTED;
      end else begin
        out_status_r  <= dup ? dtnb_pkg::ST_REPLACED : dtnb_pkg::ST_INSERTED;
        out_flushed_r <= flush_r;
      end
    end
  end

  assign status.out_free   = !out_valid_r || !out_stall;
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_match_time    = out_time_r;
  assign out_match_handle  = out_handle_r;
  assign out_store_flushed = out_flushed_r;
  assign out_fill_count    = out_fill_r;

endmodule

>>> hdl/depth_timestamp_nearest_buffer_unit.sv
// Time-sorted store of depth-frame handles that answers nearest-time queries.
// An item is handled in a capture and a commit state: in the cycle it is accepted every cell compares its
// timestamp with the item's time in parallel (plus the backward-jump check
// against the newest entry), and in the commit state the row of cells shifts or
// replaces in one step, or the two neighbors of the insertion point are
// resolved for a query, and the result is loaded into the output register.
// The commit waits while the output register still holds a stalled result, and
// in_stall stays high until it is done; the next item is accepted right after that.
// The store is empty after reset and needs no clearing pass.
// Depends on dtnb_pkg, dtnb_ctrl and dtnb_datapath.
module depth_timestamp_nearest_buffer_unit #(
  parameter int BUFFER_DEPTH = dtnb_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [dtnb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dtnb_pkg::JUMP_W-1:0]         cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_cmd,
  input  logic [dtnb_pkg::TIME_W-1:0]         in_sample_time,
  input  logic [dtnb_pkg::HANDLE_W-1:0]       in_frame_handle,
  input  logic                                in_payload_valid,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [2:0]                          out_status,
  output logic [dtnb_pkg::TIME_W-1:0]         out_match_time,
  output logic [dtnb_pkg::HANDLE_W-1:0]       out_match_handle,
  output logic                                out_store_flushed,
  output logic [dtnb_pkg::FILL_OUT_W-1:0]     out_fill_count
);

  dtnb_pkg::ctrl_cmd_t  ctrl;
  dtnb_pkg::dp_status_t dp_status;

  dtnb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (dp_status),
    .cmd      (ctrl)
  );

  dtnb_datapath #(
    .DEPTH (BUFFER_DEPTH)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_cmd            (in_cmd),
    .in_sample_time    (in_sample_time),
    .in_frame_handle   (in_frame_handle),
    .in_payload_valid  (in_payload_valid),
    .ctrl              (ctrl),
    .status            (dp_status),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_match_time    (out_match_time),
    .out_match_handle  (out_match_handle),
    .out_store_flushed (out_store_flushed),
    .out_fill_count    (out_fill_count)
  );

endmodule
